// File: sv/assert_macros.svh
// Assertion macros shared by the max flow engine RTL.
// Included by each module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MFAP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Expression must never be true outside reset.
`define MFAP_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

// File: sv/mfap_pkg.sv
// Shared types, codes and constants of the max flow engine.
// Used by mfap_ctrl, mfap_dp and the top module; depends on nothing.
package mfap_pkg;

    localparam int MAX_NODES     = 64;
    localparam int MAX_EDGES_DEF = 256;
    localparam int CAP_BITS_DEF  = 32;
    localparam int NODE_W        = 6;
    localparam int AMOUNT_W      = 40;
    localparam int NC_W          = 7;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_CHANGE = 3'd1;
    localparam logic [2:0] OP_FLOW   = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CUT    = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_RANGE     = 3'd1;
    localparam logic [2:0] STAT_INDEX     = 3'd2;
    localparam logic [2:0] STAT_FLOW      = 3'd3;
    localparam logic [2:0] STAT_SRC_SINK  = 3'd4;

    typedef struct packed {
        logic [2:0]        operation;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [31:0]       capacity;
        logic [31:0]       edge_flow;
        logic [7:0]        edge_index;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] sink_node;
        logic [31:0]       limit_amount;
        logic              limit_enable;
    } t_request;

    typedef struct packed {
        logic [7:0]          edge_id;
        logic [AMOUNT_W-1:0] amount;
        logic [31:0]         edge_capacity;
        logic [NODE_W-1:0]   node;
        logic                source_side;
        logic                last;
        logic [2:0]          status;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_ERR_OUT, S_ADD_LO, S_ADD_HI, S_CHG_LO, S_CHG_HI,
        S_RD_A, S_RD_B, S_RD_C, S_FLOW_INIT, S_ROUND, S_SCAN_RD, S_SCAN_EV,
        S_POP, S_POP_LD, S_AUG_STK, S_AUG_X, S_AUG_R1, S_AUG_R2, S_AUG_W,
        S_ACCUM, S_FLOW_OUT, S_CUT_INIT, S_CUT_PASS, S_CUT_RD, S_CUT_EV,
        S_CUT_OUT
    } t_state;

    typedef enum logic [4:0] {
        C_NOP, C_LATCH, C_ERR_OUT, C_ADD_LO, C_ADD_HI, C_CHG_LO, C_CHG_HI,
        C_RD_A, C_RD_B, C_RD_C, C_FLOW_INIT, C_ROUND, C_SCAN_RD, C_SCAN_EV,
        C_POP, C_POP_LD, C_AUG_STK, C_AUG_X, C_AUG_R1, C_AUG_R2, C_AUG_W,
        C_ACCUM, C_FLOW_OUT, C_CUT_INIT, C_CUT_PASS, C_CUT_RD, C_CUT_EV,
        C_CUT_OUT
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       has_err;
        logic       arc_end;
        logic       match;
        logic       head_is_sink;
        logic       depth_one;
        logic       limit_zero;
        logic       src_eq_sink;
        logic       aug_last;
        logic       changed;
        logic       cut_last;
    } t_flags;

endpackage

// File: sv/mfap_ram.sv
// Generic single write port RAM with a registered read port.
// Holds the arc table, the residual table and the search stack; no dependencies.
module mfap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: sv/mfap_ctrl.sv
// Sequencer of the max flow engine: one state machine issuing datapath commands.
// Depends on mfap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfap_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  mfap_pkg::t_flags  i_flags,
    output logic              busy,
    output mfap_pkg::t_cmd    o_cmd
);

    mfap_pkg::t_state r_state;
    mfap_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfap_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = mfap_pkg::C_NOP;
        busy    = 1'b1;
        unique case (r_state)
            mfap_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd   = mfap_pkg::C_LATCH;
                    n_state = mfap_pkg::S_DISPATCH;
                end
            end
            mfap_pkg::S_DISPATCH: begin
                unique case (i_flags.op)
                    mfap_pkg::OP_ADD:    n_state = i_flags.has_err ?
                        mfap_pkg::S_ERR_OUT : mfap_pkg::S_ADD_LO;
                    mfap_pkg::OP_CHANGE: n_state = i_flags.has_err ?
                        mfap_pkg::S_ERR_OUT : mfap_pkg::S_CHG_LO;
                    mfap_pkg::OP_FLOW:   n_state = i_flags.has_err ?
                        mfap_pkg::S_ERR_OUT : mfap_pkg::S_FLOW_INIT;
                    mfap_pkg::OP_READ:   n_state = i_flags.has_err ?
                        mfap_pkg::S_ERR_OUT : mfap_pkg::S_RD_A;
                    mfap_pkg::OP_CUT:    n_state = i_flags.has_err ?
                        mfap_pkg::S_ERR_OUT : mfap_pkg::S_CUT_INIT;
                    default:             n_state = mfap_pkg::S_IDLE;
                endcase
            end
            mfap_pkg::S_ERR_OUT: begin
                o_cmd   = mfap_pkg::C_ERR_OUT;
                n_state = mfap_pkg::S_IDLE;
            end
            mfap_pkg::S_ADD_LO: begin
                o_cmd   = mfap_pkg::C_ADD_LO;
                n_state = mfap_pkg::S_ADD_HI;
            end
            mfap_pkg::S_ADD_HI: begin
                o_cmd   = mfap_pkg::C_ADD_HI;
                n_state = mfap_pkg::S_IDLE;
            end
            mfap_pkg::S_CHG_LO: begin
                o_cmd   = mfap_pkg::C_CHG_LO;
                n_state = mfap_pkg::S_CHG_HI;
            end
            mfap_pkg::S_CHG_HI: begin
                o_cmd   = mfap_pkg::C_CHG_HI;
                n_state = mfap_pkg::S_IDLE;
            end
            mfap_pkg::S_RD_A: begin
                o_cmd   = mfap_pkg::C_RD_A;
                n_state = mfap_pkg::S_RD_B;
            end
            mfap_pkg::S_RD_B: begin
                o_cmd   = mfap_pkg::C_RD_B;
                n_state = mfap_pkg::S_RD_C;
            end
            mfap_pkg::S_RD_C: begin
                o_cmd   = mfap_pkg::C_RD_C;
                n_state = mfap_pkg::S_IDLE;
            end
            mfap_pkg::S_FLOW_INIT: begin
                o_cmd   = mfap_pkg::C_FLOW_INIT;
                n_state = mfap_pkg::S_ROUND;
            end
            mfap_pkg::S_ROUND: begin
                o_cmd = mfap_pkg::C_ROUND;
                if (i_flags.limit_zero) begin
                    n_state = mfap_pkg::S_FLOW_OUT;
                end else if (i_flags.src_eq_sink) begin
                    n_state = mfap_pkg::S_ACCUM;
                end else begin
                    n_state = mfap_pkg::S_SCAN_RD;
                end
            end
            mfap_pkg::S_SCAN_RD: begin
                o_cmd   = mfap_pkg::C_SCAN_RD;
                n_state = i_flags.arc_end ? mfap_pkg::S_POP : mfap_pkg::S_SCAN_EV;
            end
            mfap_pkg::S_SCAN_EV: begin
                o_cmd   = mfap_pkg::C_SCAN_EV;
                n_state = (i_flags.match && i_flags.head_is_sink) ?
                    mfap_pkg::S_AUG_STK : mfap_pkg::S_SCAN_RD;
            end
            mfap_pkg::S_POP: begin
                o_cmd   = mfap_pkg::C_POP;
                n_state = i_flags.depth_one ? mfap_pkg::S_FLOW_OUT : mfap_pkg::S_POP_LD;
            end
            mfap_pkg::S_POP_LD: begin
                o_cmd   = mfap_pkg::C_POP_LD;
                n_state = mfap_pkg::S_SCAN_RD;
            end
            mfap_pkg::S_AUG_STK: begin
                o_cmd   = mfap_pkg::C_AUG_STK;
                n_state = mfap_pkg::S_AUG_X;
            end
            mfap_pkg::S_AUG_X: begin
                o_cmd   = mfap_pkg::C_AUG_X;
                n_state = mfap_pkg::S_AUG_R1;
            end
            mfap_pkg::S_AUG_R1: begin
                o_cmd   = mfap_pkg::C_AUG_R1;
                n_state = mfap_pkg::S_AUG_R2;
            end
            mfap_pkg::S_AUG_R2: begin
                o_cmd   = mfap_pkg::C_AUG_R2;
                n_state = mfap_pkg::S_AUG_W;
            end
            mfap_pkg::S_AUG_W: begin
                o_cmd   = mfap_pkg::C_AUG_W;
                n_state = i_flags.aug_last ? mfap_pkg::S_ACCUM : mfap_pkg::S_AUG_STK;
            end
            mfap_pkg::S_ACCUM: begin
                o_cmd   = mfap_pkg::C_ACCUM;
                n_state = mfap_pkg::S_ROUND;
            end
            mfap_pkg::S_FLOW_OUT: begin
                o_cmd   = mfap_pkg::C_FLOW_OUT;
                n_state = mfap_pkg::S_IDLE;
            end
            mfap_pkg::S_CUT_INIT: begin
                o_cmd   = mfap_pkg::C_CUT_INIT;
                n_state = mfap_pkg::S_CUT_PASS;
            end
            mfap_pkg::S_CUT_PASS: begin
                o_cmd   = mfap_pkg::C_CUT_PASS;
                n_state = mfap_pkg::S_CUT_RD;
            end
            mfap_pkg::S_CUT_RD: begin
                o_cmd = mfap_pkg::C_CUT_RD;
                if (!i_flags.arc_end) begin
                    n_state = mfap_pkg::S_CUT_EV;
                end else if (i_flags.changed) begin
                    n_state = mfap_pkg::S_CUT_PASS;
                end else begin
                    n_state = mfap_pkg::S_CUT_OUT;
                end
            end
            mfap_pkg::S_CUT_EV: begin
                o_cmd   = mfap_pkg::C_CUT_EV;
                n_state = mfap_pkg::S_CUT_RD;
            end
            mfap_pkg::S_CUT_OUT: begin
                o_cmd   = mfap_pkg::C_CUT_OUT;
                n_state = i_flags.cut_last ? mfap_pkg::S_IDLE : mfap_pkg::S_CUT_OUT;
            end
            default: begin
                n_state = mfap_pkg::S_IDLE;
            end
        endcase
    end

    `MFAP_ASSERT(a_start_takes, i_clk, i_rst_n, (start && !busy) |=> busy)
    `MFAP_NEVER(a_latch_only_idle, i_clk, i_rst_n,
                (o_cmd == mfap_pkg::C_LATCH) && (r_state != mfap_pkg::S_IDLE))

endmodule

// File: sv/mfap_dp.sv
// Datapath of the max flow engine: arc table, search stack, marks and result register.
// Depends on mfap_pkg, mfap_ram and assert_macros.svh.
`include "assert_macros.svh"

module mfap_dp #(
    parameter int MAX_EDGES = mfap_pkg::MAX_EDGES_DEF,
    parameter int CAP_BITS  = mfap_pkg::CAP_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mfap_pkg::t_cmd            i_cmd,
    input  mfap_pkg::t_request        i_request,
    input  logic                      i_cfg_valid,
    input  logic [mfap_pkg::NC_W-1:0] i_cfg_data,
    output mfap_pkg::t_flags          o_flags,
    output logic                      o_strobe,
    output mfap_pkg::t_result         o_result
);

    localparam int NW  = mfap_pkg::NODE_W;
    localparam int MN  = mfap_pkg::MAX_NODES;
    localparam int AMW = mfap_pkg::AMOUNT_W;
    localparam int AW  = $clog2(2 * MAX_EDGES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int RW  = CAP_BITS;
    localparam int BW  = (CAP_BITS > 32) ? CAP_BITS : 32;
    localparam int TW  = ((BW > AMW) ? BW : AMW) + 1;
    localparam int SAW = $clog2(MN);
    localparam int DW  = SAW + 1;
    localparam int SW  = NW + AW + 1 + BW;
    localparam logic [31:0] CAP_MASK32 =
        (CAP_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << CAP_BITS) - 64'd1);
    localparam logic [BW-1:0] UNLIMITED = BW'({RW{1'b1}});
    localparam logic [TW-1:0] AMOUNT_MAX = TW'({AMW{1'b1}});

    mfap_pkg::t_request    r_req;
    logic [6:0]            r_nc;
    logic [EW-1:0]         r_used;
    logic [MN-1:0]         r_visited;
    logic [MN-1:0]         r_reached;
    logic [NW-1:0]         r_v;
    logic [AW:0]           r_a;
    logic [BW-1:0]         r_b;
    logic [DW-1:0]         r_depth;
    logic [DW-1:0]         r_i;
    logic [BW-1:0]         r_got;
    logic [31:0]           r_rem;
    logic [AMW-1:0]        r_total;
    logic [AW-1:0]         r_x;
    logic [RW-1:0]         r_rx;
    logic [RW-1:0]         r_rx1;
    logic                  r_changed;
    logic [NW-1:0]         r_k;
    logic                  r_strobe;
    mfap_pkg::t_result     r_result;

    logic [6:0]            live_n;
    logic [31:0]           cap_m;
    logic [31:0]           fl_m;
    logic                  bad_index;
    logic                  table_full;
    logic [2:0]            err;
    logic [AW:0]           arcs;
    logic [AW-1:0]         used_arc;
    logic [AW-1:0]         ei_arc;
    logic [2*NW-1:0]       arc_q;
    logic [NW-1:0]         q_tail;
    logic [NW-1:0]         q_head;
    logic [RW-1:0]         res_q;
    logic [SW-1:0]         stk_q;
    logic [BW-1:0]         bb;
    logic                  match;
    logic                  cut_hit;
    logic [AW-1:0]         x_sel;
    logic [TW-1:0]         sum;

    logic                  arc_we;
    logic [AW-1:0]         arc_waddr;
    logic [2*NW-1:0]       arc_wdata;
    logic                  res_we;
    logic [AW-1:0]         res_waddr;
    logic [RW-1:0]         res_wdata;
    logic [AW-1:0]         res_raddr;
    logic                  stk_we;
    logic [SAW-1:0]        stk_raddr;

    always_comb begin
        if (r_nc == 7'd0) begin
            live_n = 7'd1;
        end else if (32'(r_nc) > MN) begin
            live_n = 7'(MN);
        end else begin
            live_n = r_nc;
        end
    end

    assign cap_m      = r_req.capacity & CAP_MASK32;
    assign fl_m       = r_req.edge_flow & CAP_MASK32;
    assign bad_index  = 32'(r_req.edge_index) >= 32'(r_used);
    assign table_full = 32'(r_used) >= MAX_EDGES;
    assign arcs       = (AW + 1)'({r_used, 1'b0});
    assign used_arc   = AW'({r_used, 1'b0});
    assign ei_arc     = AW'({r_req.edge_index, 1'b0});

    always_comb begin
        err = mfap_pkg::STAT_OK;
        case (r_req.operation)
            mfap_pkg::OP_ADD: begin
                if (7'(r_req.from_node) >= live_n || 7'(r_req.to_node) >= live_n
                    || table_full) begin
                    err = mfap_pkg::STAT_RANGE;
                end
            end
            mfap_pkg::OP_CHANGE: begin
                if (bad_index) begin
                    err = mfap_pkg::STAT_INDEX;
                end else if (fl_m > cap_m) begin
                    err = mfap_pkg::STAT_FLOW;
                end
            end
            mfap_pkg::OP_FLOW: begin
                if (7'(r_req.source_node) >= live_n || 7'(r_req.sink_node) >= live_n) begin
                    err = mfap_pkg::STAT_RANGE;
                end else if (!r_req.limit_enable && r_req.source_node == r_req.sink_node) begin
                    err = mfap_pkg::STAT_SRC_SINK;
                end
            end
            mfap_pkg::OP_READ: begin
                if (bad_index) begin
                    err = mfap_pkg::STAT_INDEX;
                end
            end
            mfap_pkg::OP_CUT: begin
                if (7'(r_req.source_node) >= live_n) begin
                    err = mfap_pkg::STAT_RANGE;
                end
            end
            default: begin
                err = mfap_pkg::STAT_OK;
            end
        endcase
    end

    assign q_tail  = arc_q[2*NW-1:NW];
    assign q_head  = arc_q[NW-1:0];
    assign bb      = (BW'(res_q) < r_b) ? BW'(res_q) : r_b;
    assign match   = (q_tail == r_v) && !r_visited[q_head] && (res_q != '0);
    assign cut_hit = r_reached[q_tail] && !r_reached[q_head] && (res_q != '0);
    assign x_sel   = (r_i == r_depth - DW'(1)) ? r_a[AW-1:0] : stk_q[BW+AW-1:BW];
    assign sum     = TW'(r_total) + TW'(r_got);

    always_comb begin
        arc_we    = 1'b0;
        arc_waddr = used_arc;
        arc_wdata = {r_req.from_node, r_req.to_node};
        res_we    = 1'b0;
        res_waddr = used_arc;
        res_wdata = RW'(cap_m);
        res_raddr = r_a[AW-1:0];
        stk_we    = 1'b0;
        stk_raddr = SAW'(r_i);
        case (i_cmd)
            mfap_pkg::C_ADD_LO: begin
                arc_we = 1'b1;
                res_we = 1'b1;
            end
            mfap_pkg::C_ADD_HI: begin
                arc_we    = 1'b1;
                arc_waddr = {used_arc[AW-1:1], 1'b1};
                arc_wdata = {r_req.to_node, r_req.from_node};
                res_we    = 1'b1;
                res_waddr = {used_arc[AW-1:1], 1'b1};
                res_wdata = '0;
            end
            mfap_pkg::C_CHG_LO: begin
                res_we    = 1'b1;
                res_waddr = ei_arc;
                res_wdata = RW'(cap_m - fl_m);
            end
            mfap_pkg::C_CHG_HI: begin
                res_we    = 1'b1;
                res_waddr = {ei_arc[AW-1:1], 1'b1};
                res_wdata = RW'(fl_m);
            end
            mfap_pkg::C_RD_A: begin
                res_raddr = ei_arc;
            end
            mfap_pkg::C_RD_B: begin
                res_raddr = {ei_arc[AW-1:1], 1'b1};
            end
            mfap_pkg::C_SCAN_EV: begin
                stk_we = match && (q_head != r_req.sink_node) && (32'(r_depth) < MN);
            end
            mfap_pkg::C_POP: begin
                stk_raddr = SAW'(r_depth - DW'(2));
            end
            mfap_pkg::C_AUG_X: begin
                res_raddr = x_sel;
            end
            mfap_pkg::C_AUG_R1: begin
                res_raddr = {r_x[AW-1:1], ~r_x[0]};
            end
            mfap_pkg::C_AUG_R2: begin
                res_we    = 1'b1;
                res_waddr = r_x;
                res_wdata = r_rx - RW'(r_got);
            end
            mfap_pkg::C_AUG_W: begin
                res_we    = 1'b1;
                res_waddr = {r_x[AW-1:1], ~r_x[0]};
                res_wdata = r_rx1 + RW'(r_got);
            end
            default: begin
                res_raddr = r_a[AW-1:0];
            end
        endcase
    end

    mfap_ram #(.WIDTH(2 * NW), .DEPTH(2 * MAX_EDGES)) u_arc_ram (
        .i_clk   (i_clk),
        .i_we    (arc_we),
        .i_waddr (arc_waddr),
        .i_wdata (arc_wdata),
        .i_raddr (r_a[AW-1:0]),
        .o_rdata (arc_q)
    );

    mfap_ram #(.WIDTH(RW), .DEPTH(2 * MAX_EDGES)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_q)
    );

    mfap_ram #(.WIDTH(SW), .DEPTH(MN)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (SAW'(r_depth - DW'(1))),
        .i_wdata ({r_v, r_a, r_b}),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc      <= 7'(MN);
            r_used    <= '0;
            r_visited <= '0;
            r_reached <= '0;
            r_total   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd inside {mfap_pkg::C_ERR_OUT, mfap_pkg::C_ADD_HI,
                                      mfap_pkg::C_CHG_HI, mfap_pkg::C_RD_C,
                                      mfap_pkg::C_FLOW_OUT, mfap_pkg::C_CUT_OUT};
            if (i_cfg_valid) begin
                r_nc <= i_cfg_data;
            end
            case (i_cmd)
                mfap_pkg::C_LATCH: begin
                    r_req <= i_request;
                end
                mfap_pkg::C_ERR_OUT: begin
                    r_result <= '{status: err, last: 1'b1, default: '0};
                end
                mfap_pkg::C_ADD_HI: begin
                    r_result <= '{edge_id: 8'(r_used), last: 1'b1, default: '0};
                    r_used   <= r_used + EW'(1);
                end
                mfap_pkg::C_CHG_HI: begin
                    r_result <= '{last: 1'b1, default: '0};
                end
                mfap_pkg::C_RD_B: begin
                    r_rx <= res_q;
                end
                mfap_pkg::C_RD_C: begin
                    r_result <= '{amount: AMW'(res_q),
                                  edge_capacity: 32'({1'b0, r_rx} + {1'b0, res_q}),
                                  last: 1'b1, default: '0};
                end
                mfap_pkg::C_FLOW_INIT: begin
                    r_total <= '0;
                    r_rem   <= r_req.limit_amount;
                end
                mfap_pkg::C_ROUND: begin
                    r_visited <= MN'(1) << r_req.source_node;
                    r_v       <= r_req.source_node;
                    r_a       <= '0;
                    r_b       <= r_req.limit_enable ? BW'(r_rem) : UNLIMITED;
                    r_depth   <= DW'(1);
                    r_got     <= BW'(r_rem);
                end
                mfap_pkg::C_SCAN_EV: begin
                    if (match) begin
                        if (q_head == r_req.sink_node) begin
                            r_got <= bb;
                            r_i   <= '0;
                        end else if (32'(r_depth) >= MN) begin
                            r_a <= r_a + (AW + 1)'(1);
                        end else begin
                            r_v               <= q_head;
                            r_a               <= '0;
                            r_b               <= bb;
                            r_visited[q_head] <= 1'b1;
                            r_depth           <= r_depth + DW'(1);
                        end
                    end else begin
                        r_a <= r_a + (AW + 1)'(1);
                    end
                end
                mfap_pkg::C_POP: begin
                    r_depth <= r_depth - DW'(1);
                end
                mfap_pkg::C_POP_LD: begin
                    r_v <= stk_q[SW-1 -: NW];
                    r_a <= stk_q[BW+AW:BW] + (AW + 1)'(1);
                    r_b <= stk_q[BW-1:0];
                end
                mfap_pkg::C_AUG_X: begin
                    r_x <= x_sel;
                end
                mfap_pkg::C_AUG_R1: begin
                    r_rx <= res_q;
                end
                mfap_pkg::C_AUG_R2: begin
                    r_rx1 <= res_q;
                end
                mfap_pkg::C_AUG_W: begin
                    r_i <= r_i + DW'(1);
                end
                mfap_pkg::C_ACCUM: begin
                    r_total <= (sum > AMOUNT_MAX) ? '1 : AMW'(sum);
                    if (r_req.limit_enable) begin
                        r_rem <= r_rem - 32'(r_got);
                    end
                end
                mfap_pkg::C_FLOW_OUT: begin
                    r_result <= '{amount: r_total, last: 1'b1, default: '0};
                end
                mfap_pkg::C_CUT_INIT: begin
                    r_reached <= MN'(1) << r_req.source_node;
                    r_k       <= '0;
                end
                mfap_pkg::C_CUT_PASS: begin
                    r_changed <= 1'b0;
                    r_a       <= '0;
                end
                mfap_pkg::C_CUT_EV: begin
                    if (cut_hit) begin
                        r_reached[q_head] <= 1'b1;
                        r_changed         <= 1'b1;
                    end
                    r_a <= r_a + (AW + 1)'(1);
                end
                mfap_pkg::C_CUT_OUT: begin
                    r_result <= '{node: r_k, source_side: r_reached[r_k],
                                  last: (7'(r_k) == live_n - 7'd1), default: '0};
                    r_k      <= r_k + NW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_flags.op           = r_req.operation;
    assign o_flags.has_err      = (err != mfap_pkg::STAT_OK);
    assign o_flags.arc_end      = (r_a >= arcs);
    assign o_flags.match        = match;
    assign o_flags.head_is_sink = (q_head == r_req.sink_node);
    assign o_flags.depth_one    = (r_depth == DW'(1));
    assign o_flags.limit_zero   = r_req.limit_enable && (r_rem == 32'd0);
    assign o_flags.src_eq_sink  = (r_req.source_node == r_req.sink_node);
    assign o_flags.aug_last     = (r_i == r_depth - DW'(1));
    assign o_flags.changed      = r_changed;
    assign o_flags.cut_last     = (7'(r_k) == live_n - 7'd1);

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `MFAP_ASSERT(a_source_marked, i_clk, i_rst_n,
                 (i_cmd == mfap_pkg::C_SCAN_RD) |-> r_visited[r_req.source_node])
    `MFAP_NEVER(a_table_bound, i_clk, i_rst_n, 32'(r_used) > MAX_EDGES)

endmodule

// File: sv/max_flow_augmenting_path.sv
// Max flow engine: a max flow run is made of rounds of arc scans, pops and path augments;
// a min cut is made of passes over the arcs and then one result per node.
// One item is worked at a time while busy is high; results are not back-pressured.
// Synchronous reset clears the edge count and sets the node count to 64; the arc table is
// left unwritten and needs no clearing pass.
module max_flow_augmenting_path #(
    parameter int MAX_EDGES = mfap_pkg::MAX_EDGES_DEF,
    parameter int CAP_BITS  = mfap_pkg::CAP_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  mfap_pkg::t_request        i_request,
    output logic                      o_strobe,
    output mfap_pkg::t_result         o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [mfap_pkg::NC_W-1:0] i_cfg_data
);

    mfap_pkg::t_cmd   cmd;
    mfap_pkg::t_flags flags;

    assign o_cfg_ready = 1'b1;

    mfap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_flags (flags),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    mfap_dp #(.MAX_EDGES(MAX_EDGES), .CAP_BITS(CAP_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_request   (i_request),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_flags     (flags),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
